// ----- sv/crr_pkg.sv -----
// ----------------------------------------------------------------------------
// crr_pkg: shared types and constants of the cost-aware replacement unit
// transaction payload structs, register indexes, policy and operation codes
// ----------------------------------------------------------------------------
package crr_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS     = 16;
	localparam int COST_W       = 32;
	localparam int STAMP_W      = 16;
	localparam int UTIL_W       = 48;
	localparam int MODE_W       = 2;
	localparam int CAP_REG_W    = 7;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 1'd1;

	// policy modes (the unused code behaves as cost mode)
	localparam logic [MODE_W-1:0] MODE_LFU  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LRU  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_COST = 2'd2;

	localparam logic [MODE_W-1:0]    MODE_RESET = MODE_LFU;
	localparam logic [CAP_REG_W-1:0] CAP_RESET  = 7'd64;

	// operations
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_HIT    = 1'b1;

	typedef struct packed {
		logic                operation;
		logic [KEY_BITS-1:0] entry_key;
		logic [COST_W-1:0]   cost;
		logic [STAMP_W-1:0]  stamp;
	} crr_in_t;

	typedef struct packed {
		logic                     evicted;
		logic [KEY_BITS-1:0]      evicted_key;
		logic                     key_found;
		logic                     victim_valid;
		logic [KEY_BITS-1:0]      victim_key;
		logic signed [UTIL_W-1:0] min_utility;
	} crr_out_t;

endpackage

// ----- sv/crr_ram.sv -----
// ----------------------------------------------------------------------------
// crr_ram: generic single write, single read memory
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module crr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/cost_aware_cache_replacement_unit.sv -----
// ----------------------------------------------------------------------------
// cost_aware_cache_replacement_unit: keyed cache replacement policy
// lfu, lru and cost-based aging utilities over a table held in one ram;
// a shared minimum/compare unit and one saturating adder under a sequencer
// ----------------------------------------------------------------------------
//
//  channel   signals                        direction  moves
//  in        in_valid in_stall in_data      into unit  one insert or hit request
//  out       out_valid out_stall out_data   out of     one result per request
//  cfg       cfg_we cfg_index cfg_data      into unit  register write, no wait
//
//  each request is worked off in two sweeps over the table ram, whose single
//  read port serialises the entries
//  after reset a clearing pass over every table entry runs before in_stall drops
//  in_stall stays high while a transaction is in work; a result held by
//  out_stall keeps the unit in its final step, a new request may be taken
//  as soon as the result has moved into the output register
//
module cost_aware_cache_replacement_unit #(
	parameter int CAPACITY = crr_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  crr_pkg::crr_in_t                 in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output crr_pkg::crr_out_t                out_data,
	input  logic                             cfg_we,
	input  logic [crr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [crr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import crr_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CW    = (CNT_W > CAP_REG_W) ? CNT_W : CAP_REG_W;
	localparam int SUM_W = UTIL_W + 2;

	localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
	localparam logic [CW-1:0]    CAP_LIM  = CW'(CAPACITY);

	localparam logic [SUM_W-1:0] ONE_SUM  = SUM_W'(65536);
	localparam logic [UTIL_W-1:0] ONE_UTIL = UTIL_W'(65536);

	// sequencer codes
	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_PREP = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	// one table entry as it sits in the ram
	typedef struct packed {
		logic                valid;
		logic [KEY_BITS-1:0] key;
		logic [UTIL_W-1:0]   util;
		logic [COST_W-1:0]   cost;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	function automatic logic [UTIL_W-1:0] sat_util(input logic [SUM_W-1:0] v);
		logic [UTIL_W-1:0] r;
		if (v[SUM_W-1:UTIL_W-1] == 3'b000 || v[SUM_W-1:UTIL_W-1] == 3'b111) begin
			r = v[UTIL_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(UTIL_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(UTIL_W-1){1'b1}}};
		end
		return r;
	endfunction

	// configuration registers
	logic [MODE_W-1:0]    mode_q;
	logic [CAP_REG_W-1:0] cap_q;

	// sequencer and sweep counter
	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] count_q;
	crr_in_t          req_q;
	logic             ev_cond_q;

	// read pipeline
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	slot_t            rdata;
	logic             upd_vld_s2;
	logic [IDX_W-1:0] upd_idx_s2;
	slot_t            upd_s2;

	// shared minimum unit
	logic                min_any_q;
	logic [IDX_W-1:0]    min_slot_q;
	logic [UTIL_W-1:0]   min_util_q;
	logic [KEY_BITS-1:0] min_key_q;

	// first sweep results
	logic              match_q;
	logic [IDX_W-1:0]  match_slot_q;
	logic [COST_W-1:0] match_cost_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_slot_q;

	// decisions taken between the sweeps
	logic                ev_q;
	logic [IDX_W-1:0]    ev_slot_q;
	logic [KEY_BITS-1:0] ev_key_q;
	logic                place_q;
	logic [IDX_W-1:0]    place_slot_q;
	logic                hit_q;
	logic [IDX_W-1:0]    hit_slot_q;
	logic [SUM_W-1:0]    addend_q;
	logic [UTIL_W-1:0]   init_util_q;

	// output register
	logic     out_valid_q;
	crr_out_t out_q;

	// combinational
	logic [CW-1:0]       cap_eff;
	logic [CW-1:0]       count_x;
	logic                sweep_rd;
	logic                cand_valid;
	logic [IDX_W-1:0]    cand_idx;
	logic [UTIL_W-1:0]   cand_util;
	logic [KEY_BITS-1:0] cand_key;
	logic                take_min;
	logic [SUM_W-1:0]    sum;
	slot_t               nw;
	logic                ev_now;
	logic                present_after;
	logic                ff_lt;
	logic [CNT_W-1:0]    count_new;
	logic [CW-1:0]       count_new_x;
	logic                vict_now;
	logic                out_free;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	slot_t               ram_wdata;

	// capacity out of range: zero acts as one, above the table size clamps
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CW'(1);
		end else if (CW'(cap_q) > CAP_LIM) begin
			cap_eff = CAP_LIM;
		end else begin
			cap_eff = CW'(cap_q);
		end
	end

	assign count_x  = CW'(count_q);
	assign sweep_rd = (state_q == ST_SCAN || state_q == ST_UPD) && (cnt_q < CAP_CNT);

	// the minimum unit looks at raw ram data in the first sweep and at the
	// rewritten entries in the second
	always_comb begin
		if (state_q == ST_SCAN) begin
			cand_valid = rd_vld_s1 && rdata.valid;
			cand_idx   = rd_idx_s1;
			cand_util  = rdata.util;
			cand_key   = rdata.key;
		end else begin
			cand_valid = upd_vld_s2 && upd_s2.valid;
			cand_idx   = upd_idx_s2;
			cand_util  = upd_s2.util;
			cand_key   = upd_s2.key;
		end
	end

	// strict less keeps the lowest slot on ties
	assign take_min = cand_valid && (!min_any_q || ($signed(cand_util) < $signed(min_util_q)));

	// the one saturating adder: aging, lfu increment or cost delta
	assign sum = {{2{rdata.util[UTIL_W-1]}}, rdata.util} + addend_q;

	always_comb begin
		nw = rdata;
		if (ev_q && rd_idx_s1 == ev_slot_q) begin
			nw.valid = 1'b0;
		end else if (ev_q && rdata.valid) begin
			nw.util = sat_util(sum);
		end
		if (hit_q && rd_idx_s1 == hit_slot_q) begin
			if (mode_q == MODE_LRU) begin
				nw.util = {{(UTIL_W-STAMP_W-16){1'b0}}, req_q.stamp, 16'h0000};
			end else begin
				nw.util = sat_util(sum);
			end
		end
		if (place_q && rd_idx_s1 == place_slot_q) begin
			nw.valid = 1'b1;
			nw.key   = req_q.entry_key;
			nw.util  = init_util_q;
			nw.cost  = req_q.cost;
		end
	end

	// eviction and placement, evaluated once the first sweep is complete
	assign ev_now        = ev_cond_q && min_any_q;
	assign present_after = match_q && !(ev_now && match_slot_q == min_slot_q);
	assign ff_lt         = free_q && (free_slot_q < min_slot_q);

	assign count_new   = count_q - CNT_W'(ev_q) + CNT_W'(place_q);
	assign count_new_x = CW'(count_new);
	assign vict_now    = (count_new_x >= cap_eff) && min_any_q;
	assign out_free    = !out_valid_q || !out_stall;

	// ram write port: clearing pass or second sweep write-back
	always_comb begin
		if (state_q == ST_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q[IDX_W-1:0];
			ram_wdata = '0;
		end else begin
			ram_we    = upd_vld_s2;
			ram_waddr = upd_idx_s2;
			ram_wdata = upd_s2;
		end
	end

	crr_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(CAPACITY)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cnt_q[IDX_W-1:0]),
		.rdata(rdata)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
			cap_q  <= CAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLICY_MODE: mode_q <= cfg_data[MODE_W-1:0];
				REG_CAPACITY:    cap_q  <= cfg_data[CAP_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// read pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			upd_vld_s2 <= 1'b0;
		end else begin
			rd_vld_s1  <= sweep_rd;
			upd_vld_s2 <= rd_vld_s1 && (state_q == ST_UPD);
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1  <= cnt_q[IDX_W-1:0];
		upd_idx_s2 <= rd_idx_s1;
		upd_s2     <= nw;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			cnt_q       <= '0;
			count_q     <= '0;
			ev_cond_q   <= 1'b0;
			min_any_q   <= 1'b0;
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			ev_q        <= 1'b0;
			place_q     <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one leaving in the same cycle
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (sweep_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (take_min) begin
				min_any_q <= 1'b1;
			end
			case (state_q)
				ST_CLR: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q[IDX_W-1:0] == LAST_IDX) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q     <= '0;
						min_any_q <= 1'b0;
						match_q   <= 1'b0;
						free_q    <= 1'b0;
						ev_cond_q <= (in_data.operation == OP_INSERT) && (count_x >= cap_eff);
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_vld_s1 && rdata.valid && rdata.key == req_q.entry_key && !match_q) begin
						match_q <= 1'b1;
					end
					if (rd_vld_s1 && !rdata.valid) begin
						free_q <= 1'b1;
					end
					if (rd_vld_s1 && rd_idx_s1 == LAST_IDX) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					cnt_q     <= '0;
					min_any_q <= 1'b0;
					ev_q      <= ev_now;
					hit_q     <= (req_q.operation == OP_HIT) && match_q;
					place_q   <= (req_q.operation == OP_INSERT) && !present_after &&
					             (free_q || ev_now);
					state_q   <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_vld_s2 && upd_idx_s2 == LAST_IDX) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						count_q <= count_new;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers of the sequencer
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			req_q <= in_data;
		end
		if (take_min) begin
			min_slot_q <= cand_idx;
			min_util_q <= cand_util;
			min_key_q  <= cand_key;
		end
		if (state_q == ST_SCAN && rd_vld_s1) begin
			if (rdata.valid && rdata.key == req_q.entry_key && !match_q) begin
				match_slot_q <= rd_idx_s1;
				match_cost_q <= rdata.cost;
			end
			if (!rdata.valid && !free_q) begin
				free_slot_q <= rd_idx_s1;
			end
		end
		if (state_q == ST_PREP) begin
			ev_slot_q    <= min_slot_q;
			ev_key_q     <= min_key_q;
			hit_slot_q   <= match_slot_q;
			place_slot_q <= (ev_now && !ff_lt) ? min_slot_q : free_slot_q;
			// aging subtracts the victim; a hit adds one or the cost delta
			if (ev_now) begin
				addend_q <= -{{2{min_util_q[UTIL_W-1]}}, min_util_q};
			end else if (mode_q == MODE_LFU) begin
				addend_q <= ONE_SUM;
			end else begin
				addend_q <= {{(SUM_W-COST_W){1'b0}}, match_cost_q} -
				            {{(SUM_W-COST_W){1'b0}}, req_q.cost};
			end
			case (mode_q)
				MODE_LFU: init_util_q <= ONE_UTIL;
				MODE_LRU: init_util_q <= {{(UTIL_W-KEY_BITS-16){1'b0}}, req_q.entry_key, 16'h0000};
				default:  init_util_q <= {{(UTIL_W-COST_W){1'b0}}, req_q.cost};
			endcase
		end
		if (state_q == ST_FIN && out_free) begin
			out_q.evicted      <= ev_q;
			out_q.evicted_key  <= ev_q ? ev_key_q : '0;
			out_q.key_found    <= hit_q;
			out_q.victim_valid <= vict_now;
			out_q.victim_key   <= vict_now ? min_key_q : '0;
			out_q.min_utility  <= vict_now ? min_util_q : '0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- bench/crr_checker.sv -----
// ----------------------------------------------------------------------------
// crr_checker: result checker for the cost-aware replacement unit
// keeps its own copy of the slot table and registers, works out the result
// of every accepted request and compares each returned transaction with it
// ----------------------------------------------------------------------------
module crr_checker #(
	parameter int CAPACITY = crr_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  crr_pkg::crr_in_t               in_data,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  crr_pkg::crr_out_t              out_data,
	input  logic                           cfg_we,
	input  logic [crr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crr_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             pending
);

	import crr_pkg::*;

	localparam longint ONE_Q16 = 65536;
	localparam longint UTIL_HI = (longint'(1) <<< (UTIL_W - 1)) - 1;
	localparam longint UTIL_LO = -UTIL_HI - 1;

	logic                 tab_valid [CAPACITY];
	logic [KEY_BITS-1:0]  tab_key   [CAPACITY];
	longint               tab_util  [CAPACITY];
	logic [COST_W-1:0]    tab_cost  [CAPACITY];
	int                   entry_count;
	logic [MODE_W-1:0]    pol_mode;
	logic [CAP_REG_W-1:0] cap_reg;

	crr_out_t outcome_q [$];
	crr_out_t want;

	function automatic longint sat48(longint v);
		if (v > UTIL_HI)
			return UTIL_HI;
		if (v < UTIL_LO)
			return UTIL_LO;
		return v;
	endfunction

	// minimum utility over valid slots, lowest slot wins a tie
	function automatic bit lowest_utility(output int slot, output longint util);
		bit any;
		any  = 1'b0;
		slot = 0;
		util = 0;
		for (int i = 0; i < CAPACITY; i++)
			if (tab_valid[i] && (!any || tab_util[i] < util)) begin
				any  = 1'b1;
				slot = i;
				util = tab_util[i];
			end
		return any;
	endfunction

	function automatic int slot_of_key(logic [KEY_BITS-1:0] key);
		for (int i = 0; i < CAPACITY; i++)
			if (tab_valid[i] && tab_key[i] == key)
				return i;
		return -1;
	endfunction

	// applies one request to the table and returns the result it must give
	function automatic crr_out_t replacement_outcome(crr_in_t req);
		crr_out_t res;
		int       cap_eff;
		int       vs;
		int       hs;
		longint   vu;
		bit       have_min;
		bit       placed;
		res = '0;
		cap_eff = int'(cap_reg);
		if (cap_eff == 0)
			cap_eff = 1;
		if (cap_eff > CAPACITY)
			cap_eff = CAPACITY;
		if (req.operation == OP_INSERT) begin
			have_min = lowest_utility(vs, vu);
			if (entry_count >= cap_eff && have_min) begin
				// aging: the victim's utility comes off every survivor
				for (int i = 0; i < CAPACITY; i++)
					if (tab_valid[i] && i != vs)
						tab_util[i] = sat48(tab_util[i] - vu);
				tab_valid[vs]   = 1'b0;
				entry_count     = entry_count - 1;
				res.evicted     = 1'b1;
				res.evicted_key = tab_key[vs];
			end
			if (slot_of_key(req.entry_key) < 0) begin
				placed = 1'b0;
				for (int i = 0; i < CAPACITY; i++)
					if (!placed && !tab_valid[i]) begin
						placed       = 1'b1;
						tab_valid[i] = 1'b1;
						tab_key[i]   = req.entry_key;
						tab_cost[i]  = req.cost;
						if (pol_mode == MODE_LFU)
							tab_util[i] = ONE_Q16;
						else if (pol_mode == MODE_LRU)
							tab_util[i] = sat48(longint'(req.entry_key) * ONE_Q16);
						else
							tab_util[i] = longint'(req.cost);
						entry_count = entry_count + 1;
					end
			end
		end else begin
			hs = slot_of_key(req.entry_key);
			if (hs >= 0) begin
				res.key_found = 1'b1;
				if (pol_mode == MODE_LFU)
					tab_util[hs] = sat48(tab_util[hs] + ONE_Q16);
				else if (pol_mode == MODE_LRU)
					tab_util[hs] = longint'(req.stamp) * ONE_Q16;
				else
					tab_util[hs] = sat48(tab_util[hs] +
						(longint'(tab_cost[hs]) - longint'(req.cost)));
			end
		end
		have_min = lowest_utility(vs, vu);
		if (entry_count >= cap_eff && have_min) begin
			res.victim_valid = 1'b1;
			res.victim_key   = tab_key[vs];
			res.min_utility  = vu[UTIL_W-1:0];
		end
		return res;
	endfunction

	task automatic check_field(input string name, input logic [UTIL_W-1:0] exp_v,
	                           input logic [UTIL_W-1:0] got_v);
		if (got_v !== exp_v) begin
			if (fail_count < 10)
				$display("crr_checker: %s expected %0h got %0h", name, exp_v, got_v);
			fail_count = fail_count + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				tab_valid[i] = 1'b0;
				tab_key[i]   = '0;
				tab_util[i]  = 0;
				tab_cost[i]  = '0;
			end
			entry_count = 0;
			pol_mode    = MODE_RESET;
			cap_reg     = CAP_RESET;
			outcome_q.delete();
			fail_count  = 0;
			pending     = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_POLICY_MODE)
					pol_mode = cfg_data[MODE_W-1:0];
				else if (cfg_index == REG_CAPACITY)
					cap_reg = cfg_data[CAP_REG_W-1:0];
			end
			if (out_valid && !out_stall) begin
				if (outcome_q.size() == 0) begin
					if (fail_count < 10)
						$display("crr_checker: result with no request outstanding");
					fail_count = fail_count + 1;
				end else begin
					want = outcome_q.pop_front();
					check_field("evicted", want.evicted, out_data.evicted);
					check_field("evicted_key", want.evicted_key, out_data.evicted_key);
					check_field("key_found", want.key_found, out_data.key_found);
					check_field("victim_valid", want.victim_valid, out_data.victim_valid);
					check_field("victim_key", want.victim_key, out_data.victim_key);
					check_field("min_utility", want.min_utility, out_data.min_utility);
				end
			end
			// queue the expected result at the tail
			if (in_valid && !in_stall)
				outcome_q.insert(outcome_q.size(), replacement_outcome(in_data));
			pending = outcome_q.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of the cost-aware replacement unit
// directed requests over field extremes and corner cases, then random phases
// under several policy and capacity settings; both channels idle at random
// ----------------------------------------------------------------------------
module tb_top;
	import crr_pkg::*;

	// spare policy code, behaves as cost mode
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	crr_in_t               in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	crr_out_t              out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_POLICY_MODE;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int fail_count;
	int pending;

	// quiet stretches: no idling on that side while set
	bit quiet_tx = 1'b0;
	bit quiet_rx = 1'b0;
	int rx_hold;
	int rx_draw;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	cost_aware_cache_replacement_unit #(
		.CAPACITY(CAPACITY_DEF)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	crr_checker #(
		.CAPACITY(CAPACITY_DEF)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// result side: after each accepted transaction draw how long the next
	// result is held off; the count only runs down while a result waits
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_hold   <= 0;
		end else if (out_valid && !out_stall) begin
			if ($urandom_range(0, 31) == 0)
				quiet_rx <= !quiet_rx;
			rx_draw = quiet_rx ? 0 : $urandom_range(0, 15);
			rx_hold   <= rx_draw;
			out_stall <= (rx_draw != 0);
		end else if (out_valid && out_stall) begin
			if (rx_hold <= 1)
				out_stall <= 1'b0;
			rx_hold <= rx_hold - 1;
		end
	end

	// one request transaction: optional gap with valid low, then hold the
	// payload until the unit takes it; valid is left high for the next call
	task automatic send_request(input logic op, input logic [KEY_BITS-1:0] key,
	                            input logic [COST_W-1:0] cost,
	                            input logic [STAMP_W-1:0] stamp);
		crr_in_t req;
		int      gap;
		if ($urandom_range(0, 31) == 0)
			quiet_tx = !quiet_tx;
		gap = quiet_tx ? 0 : $urandom_range(0, 15);
		req.operation = op;
		req.entry_key = key;
		req.cost      = cost;
		req.stamp     = stamp;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (in_stall);
	endtask

	// register writes only once every result is back and the unit is ready
	task automatic configure(input logic [MODE_W-1:0] mode,
	                         input logic [CAP_REG_W-1:0] cap);
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0 || in_stall);
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_POLICY_MODE;
		cfg_data  <= CFG_DATA_W'(mode);
		@(posedge clk);
		cfg_index <= REG_CAPACITY;
		cfg_data  <= CFG_DATA_W'(cap);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly keys from a small pool so hits and duplicates are common
	function automatic logic [KEY_BITS-1:0] pick_key(int span);
		if ($urandom_range(0, 9) == 0)
			return KEY_BITS'($urandom);
		return KEY_BITS'($urandom_range(0, span));
	endfunction

	// small whole-number costs give equal utilities and so tie-breaks
	function automatic logic [COST_W-1:0] pick_cost();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return COST_W'($urandom_range(0, 3)) << 16;
			3: return COST_W'($urandom_range(0, 255));
			default: return COST_W'($urandom);
		endcase
	endfunction

	function automatic logic [STAMP_W-1:0] pick_stamp();
		if ($urandom_range(0, 3) == 0)
			return STAMP_W'($urandom_range(0, 7));
		return STAMP_W'($urandom);
	endfunction

	initial begin
		logic [MODE_W-1:0]    mode;
		logic [CAP_REG_W-1:0] cap;
		int                   count;
		int                   span;
		int                   ins_pct;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// cost mode, two entries: empty table, field extremes, negative utility
		configure(MODE_COST, 7'd2);
		send_request(OP_HIT,    16'h0007, 32'h0000_0000, 16'h0000); // hit on empty table
		send_request(OP_INSERT, 16'h0000, 32'h0000_0000, 16'h0000);
		send_request(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF); // table now full
		send_request(OP_HIT,    16'hFFFF, 32'h0000_0000, 16'hFFFF);
		send_request(OP_HIT,    16'h0000, 32'hFFFF_FFFF, 16'h0000); // utility goes negative
		send_request(OP_INSERT, 16'hFFFF, 32'h0001_0000, 16'h0000); // duplicate after eviction
		send_request(OP_INSERT, 16'h0000, 32'h0001_0000, 16'h0000);
		send_request(OP_HIT,    16'h1234, 32'h0000_0001, 16'h0000); // key not present

		// lru with three entries: duplicate without eviction, stamp extremes
		configure(MODE_LRU, 7'd3);
		send_request(OP_INSERT, 16'hFFFF, 32'h0000_0002, 16'h0000);
		send_request(OP_INSERT, 16'h0300, 32'h0000_0010, 16'h0000);
		send_request(OP_HIT,    16'h0000, 32'h0000_0000, 16'h0000);
		send_request(OP_HIT,    16'hFFFF, 32'h0000_0000, 16'hFFFF);
		send_request(OP_INSERT, 16'h0002, 32'h0000_0001, 16'h5555);

		// lfu with capacity dropped below the entry count
		configure(MODE_LFU, 7'd1);
		send_request(OP_INSERT, 16'h0009, 32'h0000_0003, 16'h0001);
		send_request(OP_HIT,    16'h0009, 32'h0000_0000, 16'h0002);
		send_request(OP_INSERT, 16'h0009, 32'h0000_0004, 16'h0003);
		send_request(OP_INSERT, 16'h000A, 32'h0000_0005, 16'h0004);

		// spare mode code with capacity register at zero
		configure(MODE_SPARE, 7'd0);
		send_request(OP_INSERT, 16'h000B, 32'h0000_0005, 16'h0000);
		send_request(OP_HIT,    16'h000B, 32'h0000_0000, 16'hAAAA);
		send_request(OP_INSERT, 16'hAAAA, 32'h8000_0000, 16'h5555);

		// random phases; the table carries over from one setting to the next
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: begin mode = MODE_LFU;   cap = 7'd3;   count = 60;  span = 7;  ins_pct = 60; end
				1: begin mode = MODE_LRU;   cap = 7'd1;   count = 50;  span = 4;  ins_pct = 60; end
				2: begin mode = MODE_COST;  cap = 7'd5;   count = 60;  span = 12; ins_pct = 60; end
				3: begin mode = MODE_SPARE; cap = 7'd127; count = 110; span = 90; ins_pct = 80; end
				4: begin mode = MODE_LRU;   cap = 7'd64;  count = 60;  span = 90; ins_pct = 50; end
				5: begin mode = MODE_COST;  cap = 7'd0;   count = 50;  span = 6;  ins_pct = 60; end
				6: begin mode = MODE_LFU;   cap = 7'd10;  count = 70;  span = 24; ins_pct = 60; end
				7: begin mode = MODE_COST;  cap = 7'd2;   count = 60;  span = 5;  ins_pct = 55; end
				default: begin
					mode = MODE_LRU; cap = 7'd7; count = 70; span = 15; ins_pct = 60;
				end
			endcase
			configure(mode, cap);
			for (int n = 0; n < count; n++) begin
				if ($urandom_range(1, 100) <= ins_pct)
					send_request(OP_INSERT, pick_key(span), pick_cost(), pick_stamp());
				else
					send_request(OP_HIT, pick_key(span), pick_cost(), pick_stamp());
			end
		end

		// drain, then allow one transaction time for any stray result
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (150) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("cost_aware_cache_replacement_unit: match");
		else
			$display("cost_aware_cache_replacement_unit: mismatch");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("cost_aware_cache_replacement_unit: mismatch");
		$finish;
	end

endmodule
